// ----- rtl/tcp_pkg.sv -----
// Shared types, status codes and register indexes of the transfer chunk planner.
package tcp_pkg;

    localparam int BYTE_WIDTH_DEF = 64;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_MIN_ZERO   = 3'd1;
    localparam logic [2:0] STAT_MAX_BELOW  = 3'd2;
    localparam logic [2:0] STAT_ALIGN_ZERO = 3'd3;
    localparam logic [2:0] STAT_IDX_RANGE  = 3'd4;

    localparam logic [2:0] REG_TOTAL  = 3'd0;
    localparam logic [2:0] REG_SRC    = 3'd1;
    localparam logic [2:0] REG_DST    = 3'd2;
    localparam logic [2:0] REG_MIN    = 3'd3;
    localparam logic [2:0] REG_MAX    = 3'd4;
    localparam logic [2:0] REG_PREF   = 3'd5;
    localparam logic [2:0] REG_ALIGN  = 3'd6;

    // Plan derived from the set-up registers; sizes zero-extended to 64 bits.
    typedef struct packed {
        logic [2:0]  err;
        logic [63:0] size;
        logic [63:0] count;
        logic [63:0] cntm1;
        logic [63:0] tail;
        logic        tail_nz;
    } t_plan;

endpackage

// ----- rtl/tcp_plan.sv -----
// Plan unit: validates set-up, chooses chunk size and count with a shared serial divider.
module tcp_plan #(
    parameter int W = tcp_pkg::BYTE_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr,
    input  logic [W-1:0]   i_total,
    input  logic [W-1:0]   i_min,
    input  logic [W-1:0]   i_max,
    input  logic [W-1:0]   i_pref,
    input  logic [W-1:0]   i_align,
    output tcp_pkg::t_plan o_plan,
    output logic           o_busy
);
    localparam int CW = $clog2(W);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLAMP = 6'b000010,
        ST_DIV1  = 6'b000100,
        ST_FIX   = 6'b001000,
        ST_DIV2  = 6'b010000,
        ST_END   = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    logic [W-1:0]   r_quo, n_quo;
    logic [W-1:0]   r_rem, n_rem;
    logic [W-1:0]   r_d, n_d;
    logic [W-1:0]   r_c, n_c;
    logic [CW-1:0]  r_cnt, n_cnt;
    tcp_pkg::t_plan r_plan, n_plan;

    logic [W:0]     w_sh;
    logic           w_ge;
    logic [W-1:0]   w_pick, w_c, w_al, w_s0, w_s1, w_count;
    logic [2:0]     w_err;

    always_comb begin
        w_sh = {r_rem, r_quo[W-1]};
        w_ge = w_sh >= {1'b0, r_d};
        w_pick = (i_pref != '0) ? i_pref : i_min;
        w_c = (w_pick < i_min) ? i_min : ((w_pick > i_max) ? i_max : w_pick);
        w_al = r_c - r_rem;
        w_s0 = (w_al == '0) ? i_align : w_al;
        w_s1 = (w_s0 < i_min) ? i_min : ((w_s0 > i_max) ? i_max : w_s0);
        w_count = r_quo + W'(r_rem != '0);
        if (i_min == '0) begin
            w_err = tcp_pkg::STAT_MIN_ZERO;
        end else if (i_max < i_min) begin
            w_err = tcp_pkg::STAT_MAX_BELOW;
        end else if (i_align == '0) begin
            w_err = tcp_pkg::STAT_ALIGN_ZERO;
        end else begin
            w_err = tcp_pkg::STAT_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_d     = r_d;
        n_c     = r_c;
        n_cnt   = r_cnt;
        n_plan  = r_plan;
        case (r_state)
            ST_IDLE: ;
            ST_CLAMP: begin
                if (w_err != tcp_pkg::STAT_OK) begin
                    n_plan  = '0;
                    n_plan.err = w_err;
                    n_state = ST_IDLE;
                end else if (i_total == '0) begin
                    n_plan  = '0;
                    n_plan.size = 64'(w_pick);
                    n_state = ST_IDLE;
                end else begin
                    n_c     = w_c;
                    n_quo   = w_c;
                    n_rem   = '0;
                    n_d     = i_align;
                    n_cnt   = '0;
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1, ST_DIV2: begin
                // one quotient bit a cycle, restoring
                n_rem = w_ge ? W'(w_sh - {1'b0, r_d}) : w_sh[W-1:0];
                n_quo = {r_quo[W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_state = (r_state == ST_DIV1) ? ST_FIX : ST_END;
                end
            end
            ST_FIX: begin
                n_d     = w_s1;
                n_quo   = i_total;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV2;
            end
            ST_END: begin
                n_plan.err     = tcp_pkg::STAT_OK;
                n_plan.size    = 64'(r_d);
                n_plan.count   = 64'(w_count);
                n_plan.cntm1   = 64'(w_count - 1'b1);
                n_plan.tail    = 64'(r_rem);
                n_plan.tail_nz = r_rem != '0;
                n_state        = ST_IDLE;
            end
            default: n_state = ST_CLAMP;
        endcase
        if (i_cfg_wr) begin
            n_state = ST_CLAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLAMP;
        end else begin
            r_state <= n_state;
        end
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_d    <= n_d;
        r_c    <= n_c;
        r_cnt  <= n_cnt;
        r_plan <= n_plan;
    end

    assign o_plan = r_plan;
    assign o_busy = r_state != ST_IDLE;

endmodule

// ----- rtl/tcp_pipe.sv -----
// Three-stage descriptor pipeline: range check, split offset product, address sums.
module tcp_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [63:0]    i_index,
    input  tcp_pkg::t_plan i_plan,
    input  logic [63:0]    i_src_base,
    input  logic [63:0]    i_dst_base,
    output logic           o_valid,
    output logic [2:0]     o_status,
    output logic [63:0]    o_echo_index,
    output logic [63:0]    o_chunk_source,
    output logic [63:0]    o_chunk_dest,
    output logic [63:0]    o_chunk_length,
    output logic           o_is_tail_chunk,
    output logic [63:0]    o_planned_size,
    output logic [63:0]    o_planned_count
);
    // stage 1
    logic        r_v1, r_range1, r_tail1;
    logic [63:0] r_idx1, r_pl1;
    logic [31:0] r_pm1, r_pm2;
    // stage 2
    logic        r_v2, r_range2, r_tail2;
    logic [63:0] r_idx2, r_off2, r_len2;
    // stage 3
    logic        r_v3, r_tail3;
    logic [2:0]  r_stat3;
    logic [63:0] r_idx3, r_src3, r_dst3, r_len3, r_psize3, r_pcnt3;
    logic        w_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_idx1   <= i_index;
        r_range1 <= i_index >= i_plan.count;
        r_tail1  <= (i_index == i_plan.cntm1) && i_plan.tail_nz;
        r_pl1    <= 64'(i_index[31:0]) * 64'(i_plan.size[31:0]);
        r_pm1    <= 32'(i_index[31:0] * i_plan.size[63:32]);
        r_pm2    <= 32'(i_index[63:32] * i_plan.size[31:0]);

        r_idx2   <= r_idx1;
        r_range2 <= r_range1;
        r_tail2  <= r_tail1;
        r_off2   <= r_pl1 + {32'(r_pm1 + r_pm2), 32'd0};
        r_len2   <= r_tail1 ? i_plan.tail : i_plan.size;

        // zero the descriptor on any error; keep the plan on index errors
        r_idx3   <= r_idx2;
        r_stat3  <= (i_plan.err != tcp_pkg::STAT_OK) ? i_plan.err :
                    (r_range2 ? tcp_pkg::STAT_IDX_RANGE : tcp_pkg::STAT_OK);
        r_src3   <= w_ok ? i_src_base + r_off2 : '0;
        r_dst3   <= w_ok ? i_dst_base + r_off2 : '0;
        r_len3   <= w_ok ? r_len2 : '0;
        r_tail3  <= w_ok && r_tail2;
        r_psize3 <= i_plan.size;
        r_pcnt3  <= i_plan.count;
    end

    assign w_ok = (i_plan.err == tcp_pkg::STAT_OK) && !r_range2;

    assign o_valid         = r_v3;
    assign o_status        = r_stat3;
    assign o_echo_index    = r_idx3;
    assign o_chunk_source  = r_src3;
    assign o_chunk_dest    = r_dst3;
    assign o_chunk_length  = r_len3;
    assign o_is_tail_chunk = r_tail3;
    assign o_planned_size  = r_psize3;
    assign o_planned_count = r_pcnt3;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> $past(i_valid, 3))
        else $error("result strobe without a request three cycles earlier");
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_stat3 == tcp_pkg::STAT_OK) |-> (r_len3 != '0))
        else $error("good descriptor with zero length");
    a_tail_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_tail3) |-> (r_stat3 == tcp_pkg::STAT_OK))
        else $error("tail flag on a failed descriptor");

endmodule

// ----- rtl/transfer_chunk_planner_top.sv -----
// Top level of the transfer chunk planner: set-up registers, plan unit and pipeline.
// The planner answers one chunk request per cycle, each registered through the range
// check, offset and address stages after it is taken (start high, busy low); the result
// shows for one cycle with o_valid and the receiver cannot stall it. After reset and
// after every set-up write, busy stays high while the plan unit checks the set-up and,
// for a valid set-up with a nonzero total, runs its bit-serial divider twice (size
// alignment, then chunk count and tail). Write set-up registers only while no request
// is in flight. The offset product is split into 32-bit partial products across the
// pipeline stages, so requests stream back to back once the plan is ready.
module transfer_chunk_planner_top #(
    parameter int BYTE_WIDTH = tcp_pkg::BYTE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_chunk_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [63:0] o_echo_index,
    output logic [63:0] o_chunk_source,
    output logic [63:0] o_chunk_dest,
    output logic [63:0] o_chunk_length,
    output logic        o_is_tail_chunk,
    output logic [63:0] o_planned_size,
    output logic [63:0] o_planned_count
);
    // byte counts keep only their low BYTE_WIDTH bits; bases are full 64-bit
    logic [BYTE_WIDTH-1:0] r_total, r_min, r_max, r_pref, r_align;
    logic [63:0]           r_src, r_dst;
    logic                  w_wr;
    logic [BYTE_WIDTH-1:0] w_data;
    logic                  w_plan_busy;
    tcp_pkg::t_plan        w_plan;

    assign o_cfg_ready = 1'b1;
    assign w_wr   = i_cfg_valid && o_cfg_ready;
    assign w_data = i_cfg_data[BYTE_WIDTH-1:0];

    // register file; writes to unused indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_min   <= BYTE_WIDTH'(1);
            r_max   <= BYTE_WIDTH'(4096);
            r_pref  <= '0;
            r_align <= BYTE_WIDTH'(1);
        end else if (w_wr) begin
            case (i_cfg_index)
                tcp_pkg::REG_TOTAL: r_total <= w_data;
                tcp_pkg::REG_SRC:   r_src   <= i_cfg_data;
                tcp_pkg::REG_DST:   r_dst   <= i_cfg_data;
                tcp_pkg::REG_MIN:   r_min   <= w_data;
                tcp_pkg::REG_MAX:   r_max   <= w_data;
                tcp_pkg::REG_PREF:  r_pref  <= w_data;
                tcp_pkg::REG_ALIGN: r_align <= w_data;
                default: ;
            endcase
        end
    end

    tcp_plan #(.W(BYTE_WIDTH)) u_plan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (w_wr),
        .i_total  (r_total),
        .i_min    (r_min),
        .i_max    (r_max),
        .i_pref   (r_pref),
        .i_align  (r_align),
        .o_plan   (w_plan),
        .o_busy   (w_plan_busy)
    );

    // hold off requests while the plan is being recomputed
    assign busy = w_plan_busy;

    tcp_pipe u_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start && !busy),
        .i_index         (i_chunk_index),
        .i_plan          (w_plan),
        .i_src_base      (r_src),
        .i_dst_base      (r_dst),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_echo_index    (o_echo_index),
        .o_chunk_source  (o_chunk_source),
        .o_chunk_dest    (o_chunk_dest),
        .o_chunk_length  (o_chunk_length),
        .o_is_tail_chunk (o_is_tail_chunk),
        .o_planned_size  (o_planned_size),
        .o_planned_count (o_planned_count)
    );

endmodule
